>>> rtl/core/ttb_pkg.sv
package ttb_pkg;

	// Sizes of the bin store and fixed-point fraction widths
	localparam int MaxTiles     = 1024;
	localparam int BinCapacity  = 32;
	localparam int MaxTriangles = 65536;
	localparam int FracBits     = 4;
	localparam int ScaleFrac    = 8;

	localparam int TileAw  = 10;
	localparam int EntryAw = 15;
	localparam int FillW   = 6;
	localparam int TriW    = 16;
	localparam int PosW    = 38;

	// Input modes
	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TILES_ACROSS = 2'd0,
		REG_TILES_DOWN   = 2'd1,
		REG_TILE_SIZE    = 2'd2,
		REG_SPARE        = 2'd3
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRI_MUL,
		ST_TRI_LAST,
		ST_TRI_BOX,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_ENT_RD,
		ST_ENT_OUT,
		ST_EMPTY_OUT
	} state_t;

endpackage

>>> rtl/core/ttb_ram.sv
module ttb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/triangle_tile_binner_top.sv
// Channel   Direction  tdata                                  tuser / tlast
// s_axis    in         corners, offsets, scales, tile_select  tuser: mode
// m_axis    out        triangle_number, tile_start, count     tuser: has_entry, overflow; tlast
// cfg       in         cfg_data (6 bits) at cfg_index          write on cfg_we
//
// Clear and reset each sweep the 1024-entry fill memory; no transfer is taken during the sweep.
// Add transforms the corners and forms the box (one shared 20x16 multiplier, six passes),
// then walks the covered tiles with a fill memory read-modify-write for each one.
// Read forms a prefix sum over the lower tiles through the fill memory port, then streams
// the entries of the tile; a stalled result holds in the output register.
module triangle_tile_binner_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
	// offset_x, offset_y, scale_x, scale_y, tile_select, zero fill
	input  logic [207:0] s_axis_tdata,
	// mode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// triangle_number, tile_start, tile_count, zero fill
	output logic [39:0]  m_axis_tdata,
	// has_entry, overflow
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [5:0]   cfg_data
);

	ttb_pkg::state_t state_q, state_d;

	logic [5:0] across_q, down_q;
	logic [2:0] tsl_q;

	logic        [16:0] next_tri_q;
	logic               ovf_q;
	logic        [15:0] tri_q;

	logic signed [19:0] cx_q [3];
	logic signed [19:0] cy_q [3];
	logic signed [19:0] offx_q, offy_q;
	logic signed [15:0] scx_q, scy_q;
	logic        [9:0]  sel_q;

	logic        [2:0]  mul_cnt_q;
	logic signed [35:0] prod_s1;
	logic        [2:0]  pk_s1;
	logic               pv_s1;
	logic signed [37:0] lox_q, hix_q, loy_q, hiy_q;

	logic [5:0]  fx_q, ex_q, ey_q, x_q, y_q;
	logic [11:0] idx_q;
	logic [9:0]  clr_q;
	logic [9:0]  sum_i_q;
	logic [15:0] start_q;
	logic [5:0]  cnt_q;
	logic [5:0]  ent_i_q;

	logic        out_valid_q;
	logic [15:0] out_tri_q, out_start_q;
	logic [5:0]  out_cnt_q;
	logic        out_has_q, out_last_q, out_ovf_q;

	logic        in_acc, out_free, out_load;
	logic [1:0]  in_mode;
	logic [1:0]  mk;
	logic signed [19:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [37:0] p_val;
	logic        p_first, p_is_y;
	logic [4:0]  sh;
	logic signed [37:0] rnd, fxs, fys, cxs, cys, limx, limy, fxc, fyc, cxc, cyc;
	logic        box_hit;
	logic [11:0] walk_idx, grid;
	logic        walk_last_x, walk_last_y;
	logic        ent_last;

	logic                       fill_we, fill_re;
	logic [ttb_pkg::TileAw-1:0] fill_waddr, fill_raddr;
	logic [ttb_pkg::FillW-1:0]  fill_wdata, fill_rdata;
	logic                        ent_we, ent_re;
	logic [ttb_pkg::EntryAw-1:0] ent_waddr, ent_raddr;
	logic [ttb_pkg::TriW-1:0]    ent_rdata;

	assign in_mode  = s_axis_tuser;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// Shared multiplier operands: x corners then y corners
	assign mk    = (mul_cnt_q < 3'd3) ? mul_cnt_q[1:0] : 2'(mul_cnt_q - 3'd3);
	assign mul_a = (mul_cnt_q < 3'd3) ? cx_q[mk] : cy_q[mk];
	assign mul_b = (mul_cnt_q < 3'd3) ? scx_q : scy_q;

	// Transformed corner: offset * 2^8 + corner * scale
	assign p_is_y  = (pk_s1 >= 3'd3);
	assign p_first = (pk_s1 == 3'd0) || (pk_s1 == 3'd3);
	assign p_val   = (p_is_y ? ($signed({{10{offy_q[19]}}, offy_q, 8'd0}))
	                         : ($signed({{10{offx_q[19]}}, offx_q, 8'd0})))
	                 + 38'(prod_s1);

	// Tile bounds: floor of box minimum, ceiling of box maximum, clamped to the grid
	assign sh   = 5'(ttb_pkg::FracBits + ttb_pkg::ScaleFrac) + 5'(tsl_q);
	assign rnd  = $signed((38'd1 << sh) - 38'd1);
	assign fxs  = lox_q >>> sh;
	assign fys  = loy_q >>> sh;
	assign cxs  = (hix_q + rnd) >>> sh;
	assign cys  = (hiy_q + rnd) >>> sh;
	assign limx = $signed({32'd0, across_q});
	assign limy = $signed({32'd0, down_q});
	assign fxc  = (fxs < 0) ? '0 : fxs;
	assign fyc  = (fys < 0) ? '0 : fys;
	assign cxc  = (cxs > limx) ? limx : cxs;
	assign cyc  = (cys > limy) ? limy : cys;
	assign box_hit = (fxc < cxc) && (fyc < cyc);

	// Walk position
	assign walk_idx    = 12'(y_q * across_q) + 12'(x_q);
	assign walk_last_x = (7'(x_q) + 7'd1 >= 7'(ex_q));
	assign walk_last_y = (7'(y_q) + 7'd1 >= 7'(ey_q));

	// Grid size, capped to storage
	always_comb begin
		grid = 12'(across_q * down_q);
		if (grid > 12'(ttb_pkg::MaxTiles)) begin
			grid = 12'(ttb_pkg::MaxTiles);
		end
	end

	assign ent_last = (7'(ent_i_q) + 7'd1 >= 7'(cnt_q))
	               || (7'(ent_i_q) + 7'd1 >= 7'(ttb_pkg::BinCapacity));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ttb_pkg::ST_CLEAR: begin
				if (clr_q == 10'(ttb_pkg::MaxTiles - 1)) state_d = ttb_pkg::ST_IDLE;
			end
			ttb_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (in_mode)
						ttb_pkg::MODE_CLEAR: state_d = ttb_pkg::ST_CLEAR;
						ttb_pkg::MODE_ADD: begin
							if (next_tri_q < 17'(ttb_pkg::MaxTriangles))
								state_d = ttb_pkg::ST_TRI_MUL;
						end
						ttb_pkg::MODE_READ: begin
							if (12'(s_axis_tdata[201:192]) >= grid)
								state_d = ttb_pkg::ST_EMPTY_OUT;
							else
								state_d = ttb_pkg::ST_SUM_RD;
						end
						default: state_d = ttb_pkg::ST_IDLE;
					endcase
				end
			end
			ttb_pkg::ST_TRI_MUL: begin
				if (mul_cnt_q == 3'd5) state_d = ttb_pkg::ST_TRI_LAST;
			end
			ttb_pkg::ST_TRI_LAST: state_d = ttb_pkg::ST_TRI_BOX;
			ttb_pkg::ST_TRI_BOX: state_d = box_hit ? ttb_pkg::ST_WALK_RD : ttb_pkg::ST_IDLE;
			ttb_pkg::ST_WALK_RD: begin
				if (walk_idx < 12'(ttb_pkg::MaxTiles))
					state_d = ttb_pkg::ST_WALK_WR;
				else if (walk_last_x && walk_last_y)
					state_d = ttb_pkg::ST_IDLE;
			end
			ttb_pkg::ST_WALK_WR: begin
				state_d = (walk_last_x && walk_last_y) ? ttb_pkg::ST_IDLE : ttb_pkg::ST_WALK_RD;
			end
			ttb_pkg::ST_SUM_RD: state_d = ttb_pkg::ST_SUM_ACC;
			ttb_pkg::ST_SUM_ACC: begin
				if (sum_i_q != sel_q)
					state_d = ttb_pkg::ST_SUM_RD;
				else if (fill_rdata == '0)
					state_d = ttb_pkg::ST_EMPTY_OUT;
				else
					state_d = ttb_pkg::ST_ENT_RD;
			end
			ttb_pkg::ST_ENT_RD: state_d = ttb_pkg::ST_ENT_OUT;
			ttb_pkg::ST_ENT_OUT: begin
				if (out_free) state_d = ent_last ? ttb_pkg::ST_IDLE : ttb_pkg::ST_ENT_RD;
			end
			ttb_pkg::ST_EMPTY_OUT: begin
				if (out_free) state_d = ttb_pkg::ST_IDLE;
			end
			default: state_d = ttb_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and handshake outputs
	always_comb begin
		s_axis_tready = (state_q == ttb_pkg::ST_IDLE);
		fill_we    = 1'b0;
		fill_waddr = idx_q[9:0];
		fill_wdata = fill_rdata + 6'd1;
		fill_re    = 1'b0;
		fill_raddr = walk_idx[9:0];
		ent_we     = 1'b0;
		ent_waddr  = {idx_q[9:0], fill_rdata[4:0]};
		ent_re     = 1'b0;
		ent_raddr  = {sel_q, ent_i_q[4:0]};
		out_load   = 1'b0;
		case (state_q)
			ttb_pkg::ST_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
			end
			ttb_pkg::ST_WALK_RD: fill_re = (walk_idx < 12'(ttb_pkg::MaxTiles));
			ttb_pkg::ST_WALK_WR: begin
				fill_we = (fill_rdata < 6'(ttb_pkg::BinCapacity));
				ent_we  = fill_we;
			end
			ttb_pkg::ST_SUM_RD: begin
				fill_re    = 1'b1;
				fill_raddr = sum_i_q;
			end
			ttb_pkg::ST_ENT_RD:    ent_re   = 1'b1;
			ttb_pkg::ST_ENT_OUT:   out_load = out_free;
			ttb_pkg::ST_EMPTY_OUT: out_load = out_free;
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttb_pkg::ST_CLEAR;
			clr_q       <= '0;
			across_q    <= 6'd32;
			down_q      <= 6'd32;
			tsl_q       <= 3'd4;
			next_tri_q  <= '0;
			ovf_q       <= 1'b0;
			mul_cnt_q   <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= (state_q == ttb_pkg::ST_TRI_MUL);

			// Configuration writes
			if (cfg_we) begin
				case (cfg_index)
					ttb_pkg::REG_TILES_ACROSS: across_q <= cfg_data;
					ttb_pkg::REG_TILES_DOWN:   down_q   <= cfg_data;
					ttb_pkg::REG_TILE_SIZE:    tsl_q    <= cfg_data[2:0];
					default: ;
				endcase
			end

			// Clear sweep
			if (state_q == ttb_pkg::ST_CLEAR) clr_q <= clr_q + 10'd1;
			else clr_q <= '0;

			// Numbering and overflow flag
			if (in_acc && in_mode == ttb_pkg::MODE_CLEAR) begin
				next_tri_q <= '0;
				ovf_q      <= 1'b0;
			end else if (in_acc && in_mode == ttb_pkg::MODE_ADD) begin
				if (next_tri_q < 17'(ttb_pkg::MaxTriangles)) next_tri_q <= next_tri_q + 17'd1;
				else ovf_q <= 1'b1;
			end else if (state_q == ttb_pkg::ST_WALK_WR && !fill_we) begin
				ovf_q <= 1'b1;
			end

			if (state_q == ttb_pkg::ST_TRI_MUL) mul_cnt_q <= mul_cnt_q + 3'd1;
			else mul_cnt_q <= '0;

			// Output register
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q[0] <= s_axis_tdata[19:0];
			cy_q[0] <= s_axis_tdata[39:20];
			cx_q[1] <= s_axis_tdata[59:40];
			cy_q[1] <= s_axis_tdata[79:60];
			cx_q[2] <= s_axis_tdata[99:80];
			cy_q[2] <= s_axis_tdata[119:100];
			offx_q  <= s_axis_tdata[139:120];
			offy_q  <= s_axis_tdata[159:140];
			scx_q   <= s_axis_tdata[175:160];
			scy_q   <= s_axis_tdata[191:176];
			sel_q   <= s_axis_tdata[201:192];
			tri_q   <= next_tri_q[15:0];
			sum_i_q <= '0;
			start_q <= '0;
			cnt_q   <= '0;
			ent_i_q <= '0;
		end

		// Multiply, then fold into the box
		prod_s1 <= mul_a * mul_b;
		pk_s1   <= mul_cnt_q;
		if (pv_s1) begin
			if (p_is_y) begin
				if (p_first || p_val < loy_q) loy_q <= p_val;
				if (p_first || p_val > hiy_q) hiy_q <= p_val;
			end else begin
				if (p_first || p_val < lox_q) lox_q <= p_val;
				if (p_first || p_val > hix_q) hix_q <= p_val;
			end
		end

		if (state_q == ttb_pkg::ST_TRI_BOX) begin
			fx_q <= fxc[5:0];
			ex_q <= cxc[5:0];
			ey_q <= cyc[5:0];
			x_q  <= fxc[5:0];
			y_q  <= fyc[5:0];
		end

		// Advance the tile walk
		if (state_q == ttb_pkg::ST_WALK_RD) idx_q <= walk_idx;
		if ((state_q == ttb_pkg::ST_WALK_RD && walk_idx >= 12'(ttb_pkg::MaxTiles))
		    || state_q == ttb_pkg::ST_WALK_WR) begin
			if (walk_last_x) begin
				x_q <= fx_q;
				y_q <= y_q + 6'd1;
			end else begin
				x_q <= x_q + 6'd1;
			end
		end

		// Prefix sum over lower tiles
		if (state_q == ttb_pkg::ST_SUM_ACC) begin
			if (sum_i_q != sel_q) begin
				start_q <= start_q + 16'(fill_rdata);
				sum_i_q <= sum_i_q + 10'd1;
			end else begin
				cnt_q <= fill_rdata;
			end
		end

		if (state_q == ttb_pkg::ST_ENT_OUT && out_free) ent_i_q <= ent_i_q + 6'd1;

		if (out_load) begin
			out_has_q   <= (state_q == ttb_pkg::ST_ENT_OUT);
			out_tri_q   <= (state_q == ttb_pkg::ST_ENT_OUT) ? ent_rdata : '0;
			out_last_q  <= (state_q == ttb_pkg::ST_EMPTY_OUT) || ent_last;
			out_start_q <= start_q;
			out_cnt_q   <= cnt_q;
			out_ovf_q   <= ovf_q;
		end
	end

	ttb_ram #(.WIDTH(ttb_pkg::FillW), .DEPTH(ttb_pkg::MaxTiles)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	ttb_ram #(.WIDTH(ttb_pkg::TriW), .DEPTH(ttb_pkg::MaxTiles * ttb_pkg::BinCapacity)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (tri_q),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'd0, out_cnt_q, out_start_q, out_tri_q};
	assign m_axis_tuser  = {out_ovf_q, out_has_q};
	assign m_axis_tlast  = out_last_q;

	// A bin never grows past its capacity
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> fill_wdata <= 6'(ttb_pkg::BinCapacity))
		else $error("bin fill beyond capacity");

	// An entry is stored only into a bin with room
	a_entry_room: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> fill_rdata < 6'(ttb_pkg::BinCapacity))
		else $error("entry written into a full bin");

	// A held result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("output register overwritten while stalled");

	// Numbering never passes its limit
	a_num_limit: assert property (@(posedge clk) disable iff (!arst_n)
		next_tri_q <= 17'(ttb_pkg::MaxTriangles))
		else $error("triangle numbering beyond limit");

endmodule

>>> verif/ttb_checker.sv
`timescale 1ns / 100ps

module ttb_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [207:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [39:0]  m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	input  logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [5:0]   cfg_data,
	output int           pending,
	output int           fails
);

	typedef struct packed {
		logic [15:0] tri_num;
		logic [15:0] start;
		logic [5:0]  count;
		logic        has_entry;
		logic        last;
		logic        overflow;
	} tile_entry_t;

	// Mirror of the bin store and grid settings
	logic [5:0]  fill_mirror [ttb_pkg::MaxTiles];
	logic [15:0] entry_mirror [ttb_pkg::MaxTiles][ttb_pkg::BinCapacity];
	int          next_tri;
	bit          ovf_mirror;
	int          across, down, size_log2;

	tile_entry_t tile_stream_q [$];

	function automatic longint corner_pos(logic [19:0] off, logic [19:0] c,
			logic [15:0] sc);
		return longint'($signed(off)) * 256 + longint'($signed(c)) * longint'($signed(sc));
	endfunction

	// Bin one triangle into every covered tile within storage that has room
	function automatic void bin_triangle(logic [207:0] d);
		longint lo [2], hi [2], p, f [2], c [2];
		int sh, idx;
		sh = ttb_pkg::FracBits + ttb_pkg::ScaleFrac + size_log2;
		if (next_tri >= ttb_pkg::MaxTriangles) begin
			ovf_mirror = 1'b1;
			return;
		end
		for (int a = 0; a < 2; a++) begin
			for (int k = 0; k < 3; k++) begin
				p = corner_pos(d[120 + 20 * a +: 20], d[40 * k + 20 * a +: 20],
					d[160 + 16 * a +: 16]);
				if (k == 0 || p < lo[a]) lo[a] = p;
				if (k == 0 || p > hi[a]) hi[a] = p;
			end
			f[a] = lo[a] >>> sh;
			c[a] = -((-hi[a]) >>> sh);
			if (f[a] < 0) f[a] = 0;
		end
		if (c[0] > across) c[0] = across;
		if (c[1] > down) c[1] = down;
		for (longint y = f[1]; y < c[1]; y++) begin
			for (longint x = f[0]; x < c[0]; x++) begin
				idx = int'(y * across + x);
				if (idx >= ttb_pkg::MaxTiles) continue;
				if (fill_mirror[idx] >= ttb_pkg::BinCapacity) begin
					ovf_mirror = 1'b1;
					continue;
				end
				entry_mirror[idx][fill_mirror[idx]] = next_tri[15:0];
				fill_mirror[idx]++;
			end
		end
		next_tri++;
	endfunction

	// Queue the stream that a read of one tile should give
	function automatic void predict_tile_read(int sel);
		int grid, start, cnt, n;
		tile_entry_t e;
		grid = across * down;
		if (grid > ttb_pkg::MaxTiles) grid = ttb_pkg::MaxTiles;
		e = '0;
		e.last = 1'b1;
		e.overflow = ovf_mirror;
		if (sel >= grid) begin
			tile_stream_q.push_back(e);
			return;
		end
		start = 0;
		for (int i = 0; i < sel; i++) start += fill_mirror[i];
		cnt = fill_mirror[sel];
		e.start = start[15:0];
		if (cnt == 0) begin
			tile_stream_q.push_back(e);
			return;
		end
		n = (cnt > ttb_pkg::BinCapacity) ? ttb_pkg::BinCapacity : cnt;
		e.count = cnt[5:0];
		e.has_entry = 1'b1;
		for (int i = 0; i < n; i++) begin
			e.tri_num = entry_mirror[sel][i];
			e.last = (i + 1 == n);
			tile_stream_q.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tile_entry_t got, want;
		if (!arst_n) begin
			foreach (fill_mirror[i]) fill_mirror[i] = '0;
			next_tri = 0;
			ovf_mirror = 1'b0;
			across = 32;
			down = 32;
			size_log2 = 4;
			tile_stream_q.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (ttb_pkg::reg_index_t'(cfg_index))
					ttb_pkg::REG_TILES_ACROSS: across = cfg_data;
					ttb_pkg::REG_TILES_DOWN:   down = cfg_data;
					ttb_pkg::REG_TILE_SIZE:    size_log2 = cfg_data[2:0];
					default: ;
				endcase
			end
			// Predict on each input transfer
			if (s_axis_tvalid && s_axis_tready) begin
				case (ttb_pkg::mode_t'(s_axis_tuser))
					ttb_pkg::MODE_CLEAR: begin
						foreach (fill_mirror[i]) fill_mirror[i] = '0;
						next_tri = 0;
						ovf_mirror = 1'b0;
					end
					ttb_pkg::MODE_ADD:  bin_triangle(s_axis_tdata);
					ttb_pkg::MODE_READ: predict_tile_read(int'(s_axis_tdata[201:192]));
					default: ;
				endcase
			end
			// Compare each output transfer with the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[37:32],
					m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
				if (tile_stream_q.size() == 0) begin
					if (fails < 10) $display("%0t: unexpected result %p", $realtime, got);
					fails <= fails + 1;
				end else begin
					want = tile_stream_q.pop_front();
					if (got !== want) begin
						if (fails < 10)
							$display("%0t: mismatch expected %p actual %p", $realtime, want, got);
						fails <= fails + 1;
					end
				end
			end
			pending <= tile_stream_q.size();
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int STALL_LIMIT = 20000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [207:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [39:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [5:0]   cfg_data = '0;
	int           pending, fails;
	int           send_pct = 22, recv_pct = 54;
	int           quiet_cycles = 0;
	int           grid_across = 32, grid_down = 32, grid_log2 = 4;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	triangle_tile_binner_top DUT (.*);

	ttb_checker u_checker (.*);

	// Receiver back-pressure
	always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_pct);

	// Watchdog on cycles without a transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [207:0] pack_tri(logic [19:0] c0x, c0y, c1x, c1y, c2x, c2y,
			logic [19:0] ox, oy, logic [15:0] sx, sy, logic [9:0] sel);
		return {6'b0, sel, sy, sx, oy, ox, c2y, c2x, c1y, c1x, c0y, c0x};
	endfunction

	// Offer one transfer, idling at random beforehand
	task automatic send_item(ttb_pkg::mode_t m, logic [207:0] d);
		logic ok;
		if ($urandom_range(99) < send_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= m;
		s_axis_tdata <= d;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
	endtask

	// Hold the sender until every result has come and the block is idle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || !s_axis_tready) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_grid(int ac, int dn, int lg);
		drain();
		grid_across = ac;
		grid_down = dn;
		grid_log2 = lg;
		cfg_we <= 1'b1;
		cfg_index <= ttb_pkg::REG_TILES_ACROSS;
		cfg_data <= 6'(ac);
		@(posedge clk);
		cfg_index <= ttb_pkg::REG_TILES_DOWN;
		cfg_data <= 6'(dn);
		@(posedge clk);
		cfg_index <= ttb_pkg::REG_TILE_SIZE;
		cfg_data <= 6'(lg);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_simple(int x0, y0, x1, y1, x2, y2);
		send_item(ttb_pkg::MODE_ADD, pack_tri(20'(x0), 20'(y0), 20'(x1), 20'(y1), 20'(x2),
			20'(y2), '0, '0, 16'sd256, 16'sd256, '0));
	endtask

	task automatic read_tile(int sel);
		send_item(ttb_pkg::MODE_READ, pack_tri('0, '0, '0, '0, '0, '0, '0, '0, '0, '0,
			10'(sel)));
	endtask

	// Well-formed add: a small box near the grid, or one over the whole grid
	task automatic random_add();
		int tpx, gx, gy, bx, by;
		int xs [3], ys [3];
		logic [15:0] sx, sy;
		logic [19:0] ox, oy;
		tpx = 16 << grid_log2;
		gx = (grid_across + 1) * tpx;
		gy = (grid_down + 1) * tpx;
		if ($urandom_range(99) < 25) begin
			xs = '{-tpx, gx, $urandom_range(gx)};
			ys = '{$urandom_range(gy), -tpx, gy};
		end else begin
			bx = $urandom_range(gx) - tpx;
			by = $urandom_range(gy) - tpx;
			for (int k = 0; k < 3; k++) begin
				xs[k] = bx + $urandom_range(3 * tpx);
				ys[k] = by + $urandom_range(3 * tpx);
			end
		end
		sx = 16'sd256;
		sy = 16'sd256;
		ox = '0;
		oy = '0;
		if ($urandom_range(3) == 0) begin
			sx = 16'($urandom_range(384, 128));
			sy = 16'($urandom_range(384, 128));
			ox = 20'($urandom_range(2 * tpx) - tpx);
			oy = 20'($urandom_range(2 * tpx) - tpx);
		end
		send_item(ttb_pkg::MODE_ADD, pack_tri(20'(xs[0]), 20'(ys[0]), 20'(xs[1]), 20'(ys[1]),
			20'(xs[2]), 20'(ys[2]), ox, oy, sx, sy, '0));
	endtask

	task automatic random_item();
		int r, grid;
		r = $urandom_range(99);
		grid = grid_across * grid_down;
		if (grid > ttb_pkg::MaxTiles) grid = ttb_pkg::MaxTiles;
		if (r < 55)
			random_add();
		else if (r < 85)
			read_tile((grid > 0 && r < 80) ? $urandom_range(grid - 1) : $urandom_range(1023));
		else if (r < 88)
			send_item(ttb_pkg::MODE_CLEAR, '0);
		else
			// noise: any mode, any bits
			send_item(ttb_pkg::mode_t'($urandom_range(3)), 208'({$urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom}));
	endtask

	initial begin
		int grids [6][3];
		int counts [6];
		int done_items;
		grids = '{'{32, 32, 4}, '{2, 2, 3}, '{1, 1, 2}, '{63, 63, 7}, '{0, 5, 5},
			'{7, 5, 6}};
		counts = '{20, 40, 10, 12, 6, 18};
		done_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes and special cases at the reset grid
		read_tile(0);
		add_simple(16, 16, 100, 40, 60, 200);
		add_simple(256, 256, 256, 256, 256, 256);          // box on a tile edge
		add_simple(-200, -200, -100, -50, -300, -10);      // entirely off grid
		add_simple(-524288, -524288, 524287, 524287, 0, 0); // whole grid
		send_item(ttb_pkg::MODE_ADD, pack_tri(20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000,
			20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000, 16'h7FFF, 16'h8000, 10'h3FF));
		send_item(ttb_pkg::MODE_ADD, pack_tri(20'sd100, 20'sd100, 20'sd300, 20'sd90,
			20'sd200, 20'sd400, 20'sd1000, 20'sd500, -16'sd256, -16'sd128, 10'd0));
		send_item(ttb_pkg::MODE_ADD, pack_tri(20'sd1, 20'sd1, 20'sd2, 20'sd2, 20'sd3, 20'sd3,
			20'sd2000, 20'sd3000, 16'sd0, 16'sd0, 10'd0));
		send_item(ttb_pkg::MODE_NONE, '1);
		read_tile(0);
		read_tile(1);
		read_tile(33);
		read_tile(1023);
		read_tile(500);
		send_item(ttb_pkg::MODE_CLEAR, '0);
		read_tile(0);
		add_simple(0, 0, 15, 15, 8, 8);
		read_tile(0);

		foreach (counts[p]) begin
			set_grid(grids[p][0], grids[p][1], grids[p][2]);
			for (int i = 0; i < counts[p]; i++) begin
				if (done_items == 35) begin
					send_pct = 54;
					recv_pct = 22;
				end else if (done_items == 70) begin
					send_pct = 0;
					recv_pct = 0;
				end
				random_item();
				done_items++;
			end
			read_tile(0);
		end

		drain();
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> triangle_tile_binner_top.f
rtl/core/ttb_pkg.sv
rtl/core/ttb_ram.sv
rtl/core/triangle_tile_binner_top.sv
verif/ttb_checker.sv
verif/tb.sv
